FILE: hw/rtl/mam_pkg.sv
`default_nettype none
package mam_pkg;

  localparam int unsigned CHANNELS_DEF     = 8;
  localparam int unsigned SAMPLE_DEPTH_DEF = 4096;
  localparam int unsigned MASK_W           = 8;
  localparam logic [6:0]  PCT_FULL         = 7'd100;

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_PLAY   = 3'd1,
    FUNC_STOP   = 3'd2,
    FUNC_SETVOL = 3'd3,
    FUNC_WRITE  = 3'd4,
    FUNC_STOPALL = 3'd5
  } func_t;

  typedef enum logic [0:0] {
    CFG_MASTER = 1'b0,
    CFG_BGM    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BGM,
    ST_VREAD,
    ST_VADD,
    ST_SUM,
    ST_MASTER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [2:0]         channel;
    logic [11:0]        word_index;
    logic signed [15:0] sample_word;
    logic [12:0]        play_length;
    logic               loop_enable;
    logic [6:0]         volume;
    logic signed [15:0] bgm_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic               granted;
    logic [2:0]         voice_id;
    logic [7:0]         active_mask;
  } out_item_t;

  // request to the shared scaler: x*v/100 truncated toward zero
  typedef struct packed {
    logic signed [15:0] x;
    logic [6:0]         v;
  } scale_req_t;

  function automatic logic [6:0] clamp_pct(input logic [6:0] v);
    clamp_pct = (v > PCT_FULL) ? PCT_FULL : v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
    if (x > 18'sd32767) sat16 = 16'sh7fff;
    else if (x < -18'sd32768) sat16 = 16'sh8000;
    else sat16 = x[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mam_scaler.sv
`default_nettype none
// registered x*v/100, one request per cycle, result ready in the next cycle
module mam_scaler (
  input  wire logic                  clk,
  input  wire mam_pkg::scale_req_t   req,
  output logic signed [15:0]         result
);
  import mam_pkg::*;

  logic signed [23:0] prod;
  logic [22:0]        mag;
  logic [39:0]        recip;
  logic [16:0]        q;
  logic [22:0]        rem;
  logic [16:0]        q_fix;
  logic signed [15:0] result_nxt;

  always_comb begin
    prod  = req.x * $signed({1'b0, clamp_pct(req.v)});
    mag   = prod[23] ? 23'(-prod) : prod[22:0];
    // floor(mag/100) by reciprocal, then one correction
    recip = 40'(mag) * 40'd41943;
    q     = recip[38:22];
    rem   = mag - 23'(q) * 23'd100;
    q_fix = (rem >= 23'd100) ? q + 17'd1 : q;
    result_nxt = prod[23] ? 16'(-$signed({1'b0, q_fix})) : q_fix[15:0];
  end

  always_ff @(posedge clk) begin
    result <= result_nxt;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/multichannel_audio_mixer.sv
`default_nettype none
// channel  direction  handshake
// in_*     input      in_valid / in_stall (stall driven here)
// out_*    output     out_valid / out_stall (stall driven by sink)
// cfg_*    input      cfg_valid / cfg_ready
// a tick steps through bgm, one store read and one scaler pass per voice, the
// last add and master before done registers its result; other requests go
// straight to done, and the next request enters once back in idle
// the shared scaler and the single-port sample store set this sequence
// synchronous active-low reset clears voice state and sets volumes to full; store undefined
// a finished result waits in the output register while the next request enters
module multichannel_audio_mixer #(
  parameter int unsigned CHANNELS     = mam_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_DEPTH = mam_pkg::SAMPLE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mam_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mam_pkg::out_item_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [6:0]          cfg_data
);
  import mam_pkg::*;

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned LW = AW + 1;

  state_t state_r, state_nxt;
  in_item_t req_r;
  logic [6:0] master_r, bgm_r;
  logic [CHANNELS-1:0] act_r, loop_r;
  logic [LW-1:0] pos_r [CHANNELS];
  logic [LW-1:0] len_r [CHANNELS];
  logic [6:0]    vol_r [CHANNELS];
  logic [CW-1:0] vc_r;
  logic signed [15:0] sum_r;
  logic          add_r;
  logic          ovalid_r;
  out_item_t     odata_r;

  logic signed [15:0] mem [CHANNELS*SAMPLE_DEPTH];
  logic signed [15:0] rd_r;

  scale_req_t sreq;
  logic signed [15:0] sres;

  mam_scaler u_scaler (.clk(clk), .req(sreq), .result(sres));

  logic in_acc, last_vc;
  logic [AW-1:0] rd_pos;
  logic plays;
  logic plays_q;
  logic wrap;
  logic [CW-1:0] free_id;
  logic free_any;
  logic [7:0] mask;

  assign in_acc  = in_valid && !in_stall;
  assign last_vc = (32'(vc_r) == CHANNELS - 1);
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // voice status for the current voice during a tick
  always_comb begin
    wrap  = pos_r[vc_r] >= len_r[vc_r];
    plays = act_r[vc_r] && (len_r[vc_r] != '0) && (!wrap || loop_r[vc_r]);
    rd_pos = wrap ? '0 : pos_r[vc_r][AW-1:0];
  end

  always_comb begin
    free_any = 1'b0;
    free_id  = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (!act_r[c]) begin
        free_any = 1'b1;
        free_id  = CW'(c);
      end
    end
  end

  always_comb begin
    mask = '0;
    for (int c = 0; c < CHANNELS && c < MASK_W; c++) mask[c] = act_r[c];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = (func_t'(in_data.func) == FUNC_TICK) ? ST_BGM : ST_DONE;
      ST_BGM:    state_nxt = ST_VREAD;
      ST_VREAD:  state_nxt = ST_VADD;
      ST_VADD:   state_nxt = last_vc ? ST_SUM : ST_VREAD;
      ST_SUM:    state_nxt = ST_MASTER;
      ST_MASTER: state_nxt = ST_DONE;
      ST_DONE:   if (!ovalid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    sreq.x = req_r.bgm_sample;
    sreq.v = bgm_r;
    unique case (state_r)
      ST_VADD:   begin sreq.x = rd_r;  sreq.v = vol_r[vc_r]; end
      ST_MASTER, ST_DONE: begin sreq.x = sum_r; sreq.v = master_r; end
      default:   begin sreq.x = req_r.bgm_sample; sreq.v = bgm_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_VREAD) rd_r <= mem[{vc_r, rd_pos}];
    if (state_r == ST_DONE && func_t'(req_r.func) == FUNC_WRITE &&
        32'(req_r.channel) < CHANNELS && 32'(req_r.word_index) < SAMPLE_DEPTH)
      mem[{req_r.channel[CW-1:0], req_r.word_index[AW-1:0]}] <= req_r.sample_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      master_r <= PCT_FULL;
      bgm_r <= PCT_FULL;
      act_r <= '0;
      loop_r <= '0;
      ovalid_r <= 1'b0;
      add_r <= 1'b0;
      vc_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c] <= '0;
        len_r[c] <= '0;
        vol_r[c] <= PCT_FULL;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_MASTER) master_r <= cfg_data;
        else bgm_r <= cfg_data;
      end
      if (state_r != ST_DONE && ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (in_acc) req_r <= in_data;
      // scaler result of previous cycle is folded in here
      if (add_r) sum_r <= sat16(18'(sum_r) + 18'(sres));
      add_r <= 1'b0;
      unique case (state_r)
        ST_BGM: vc_r <= '0;
        ST_VREAD: begin
          if (act_r[vc_r] && len_r[vc_r] != '0 && wrap && !loop_r[vc_r])
            act_r[vc_r] <= 1'b0;
          if (plays) pos_r[vc_r] <= LW'(rd_pos) + LW'(1);
        end
        ST_VADD: begin
          if (state_r == ST_VADD && 32'(vc_r) == 0) sum_r <= sres;
          add_r <= plays_q;
          if (!last_vc) vc_r <= vc_r + CW'(1);
        end
        ST_MASTER: ;
        ST_DONE: begin
          if (!ovalid_r || !out_stall) begin
            ovalid_r <= 1'b1;
            odata_r.mixed_sample <= '0;
            odata_r.granted <= 1'b0;
            odata_r.voice_id <= '0;
            odata_r.active_mask <= mask;
            unique case (func_t'(req_r.func))
              FUNC_TICK: odata_r.mixed_sample <= sres;
              FUNC_PLAY: if (free_any) begin
                act_r[free_id] <= 1'b1;
                loop_r[free_id] <= req_r.loop_enable;
                pos_r[free_id] <= '0;
                vol_r[free_id] <= PCT_FULL;
                len_r[free_id] <= (32'(req_r.play_length) > SAMPLE_DEPTH) ?
                                  LW'(SAMPLE_DEPTH) : LW'(req_r.play_length);
                odata_r.granted <= 1'b1;
                odata_r.voice_id <= 3'(free_id);
                odata_r.active_mask <= mask | (MASK_W'(1) << free_id);
              end
              FUNC_STOP: if (32'(req_r.channel) < CHANNELS) begin
                act_r[req_r.channel[CW-1:0]] <= 1'b0;
                pos_r[req_r.channel[CW-1:0]] <= '0;
                len_r[req_r.channel[CW-1:0]] <= '0;
                odata_r.active_mask <= mask & ~(MASK_W'(1) << req_r.channel);
              end
              FUNC_SETVOL: if (32'(req_r.channel) < CHANNELS)
                vol_r[req_r.channel[CW-1:0]] <= clamp_pct(req_r.volume);
              FUNC_STOPALL: begin
                act_r <= '0;
                for (int c = 0; c < CHANNELS; c++) begin
                  pos_r[c] <= '0;
                  len_r[c] <= '0;
                end
                odata_r.active_mask <= '0;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // each voice result arrives in the cycle after its vadd
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plays_q <= 1'b0;
    end else begin
      if (state_r == ST_VREAD) plays_q <= plays;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("request accepted without leaving idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && out_stall) |=> $stable(odata_r))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MASTER |-> $past(state_r) == ST_SUM)
    else $error("master scaling out of sequence");

endmodule
`default_nettype wire
